// ===== hw/rtl/ftlpf_pkg.sv =====
// Shared constants for the first-touch line prefetch filter.
`timescale 1ns / 1ps
`default_nettype none

package ftlpf_pkg;

  localparam int unsigned MaxLinesDef   = 1024;
  localparam int unsigned TileIdBitsDef = 16;

  // line index field width (signed)
  localparam int unsigned LineW = 11;

  // lines-per-tile register
  localparam int unsigned TileLinesW = 11;
  localparam logic [TileLinesW-1:0] TileLinesRst = 11'd1024;

  // visited-line tags: one epoch per tile switch
  localparam int unsigned EpochW = 8;
  localparam logic [EpochW-1:0] EpochMax = '1;

endpackage

`default_nettype wire

// ===== hw/rtl/ftlpf_visit_map.sv =====
// Visited-line tag memory with a sweep that zeroes every entry.
`timescale 1ns / 1ps
`default_nettype none

module ftlpf_visit_map #(
  parameter int unsigned Depth = ftlpf_pkg::MaxLinesDef,
  parameter int unsigned IdxW  = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [IdxW-1:0]             rd_addr_i,
  output logic      [ftlpf_pkg::EpochW-1:0] rd_tag_o,
  input  wire logic                        wr_en_i,
  input  wire logic [IdxW-1:0]             wr_addr_i,
  input  wire logic [ftlpf_pkg::EpochW-1:0] wr_tag_i,
  input  wire logic                        clr_start_i,
  output logic                             clr_busy_o
);

  logic [ftlpf_pkg::EpochW-1:0] mem_q [Depth];
  logic [ftlpf_pkg::EpochW-1:0] rd_tag_q;
  logic [IdxW-1:0]              clr_cnt_q;
  logic                         clr_busy_q;

  // sweep runs after reset and on request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == IdxW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
        clr_cnt_q  <= '0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end else if (clr_start_i) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_tag_i;
    end
    if (rd_en_i) begin
      rd_tag_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_tag_o   = rd_tag_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ===== hw/rtl/first_touch_line_prefetch_filter.sv =====
// Top level: first-touch line filter issuing one prefetch per newly touched line.
//
//  channel | handshake                    | word
//  --------+------------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o      | cur/req/next tile, line index, payload
//  out     | out_valid_o / out_ready_i    | prefetch flag, prefetch tile, payload
//  cfg     | cfg_valid_i / cfg_ready_o    | lines per tile (always ready)
//
// One word per cycle unless the output stalls or a sweep runs; result follows stage 1.
// After reset the tag memory is swept with in_ready_o low.
// Each tile switch takes a new 8-bit epoch; when the epochs run out, the word
// causing the switch holds while the memory is swept (once per 255 switches).
// A stalled output holds the word in flight, then back-pressures the input.
`timescale 1ns / 1ps
`default_nettype none

module first_touch_line_prefetch_filter #(
  parameter int unsigned MAX_LINES    = ftlpf_pkg::MaxLinesDef,
  parameter int unsigned TILE_ID_BITS = ftlpf_pkg::TileIdBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ftlpf_pkg::TileLinesW-1:0]    cfg_data_i,
  // requests
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [TILE_ID_BITS:0]        cur_tile_i,
  input  wire logic signed [TILE_ID_BITS:0]        req_tile_i,
  input  wire logic signed [ftlpf_pkg::LineW-1:0]  line_index_i,
  input  wire logic signed [TILE_ID_BITS:0]        next_tile_i,
  input  wire logic [63:0]                         request_payload_i,
  // prefetch results
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     do_prefetch_o,
  output logic [TILE_ID_BITS-1:0]                  prefetch_tile_o,
  output logic [63:0]                              prefetch_payload_o
);

  localparam int unsigned TW    = TILE_ID_BITS + 1;
  localparam int unsigned IdxW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned LineW = ftlpf_pkg::LineW;
  localparam int unsigned EpW   = ftlpf_pkg::EpochW;

  // config register
  logic [ftlpf_pkg::TileLinesW-1:0] lines_per_tile_q;

  // stage 1: accepted word
  logic                    s1_valid_q;
  logic signed [TW-1:0]    s1_cur_q, s1_req_q, s1_nxt_q;
  logic signed [LineW-1:0] s1_line_q;
  logic [63:0]             s1_payload_q;

  // filter state
  logic signed [TW-1:0] active_q, initial_q;
  logic [EpW-1:0]       epoch_q;

  // last tag written, for a read issued at the same edge
  logic            fw_valid_q;
  logic [IdxW-1:0] fw_addr_q;
  logic [EpW-1:0]  fw_tag_q;

  // result register
  logic                    out_valid_q;
  logic                    out_do_q;
  logic [TILE_ID_BITS-1:0] out_tile_q;
  logic [63:0]             out_payload_q;

  logic            accept;
  logic [31:0]     in_line_ext, s1_line_ext;
  logic [IdxW-1:0] in_addr, s1_addr;
  logic [EpW-1:0]  rd_tag, tag;
  logic            clr_busy, clr_start;
  logic            line_ok, qual, change, need_wrap, adv, visited, fire;
  logic [EpW-1:0]  epoch_d;
  logic signed [TW-1:0] initial_d, target;

  assign in_line_ext = 32'(unsigned'(line_index_i));
  assign s1_line_ext = 32'(unsigned'(s1_line_q));
  assign in_addr     = in_line_ext[IdxW-1:0];
  assign s1_addr     = s1_line_ext[IdxW-1:0];

  assign line_ok = !s1_line_q[LineW-1]
                && ({1'b0, s1_line_q[LineW-2:0]} < lines_per_tile_q)
                && (s1_line_ext < 32'(MAX_LINES));
  assign qual    = !s1_cur_q[TW-1] && (s1_req_q == s1_cur_q) && line_ok;
  assign change  = (s1_cur_q != active_q);

  assign need_wrap = s1_valid_q && qual && change && (epoch_q == ftlpf_pkg::EpochMax);
  assign clr_start = need_wrap && !clr_busy;

  assign adv        = s1_valid_q && !clr_busy && !need_wrap && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy && (!s1_valid_q || adv);
  assign accept     = in_valid_i && in_ready_o;

  assign tag      = (fw_valid_q && (fw_addr_q == s1_addr)) ? fw_tag_q : rd_tag;
  assign epoch_d  = change ? epoch_q + 1'b1 : epoch_q;
  // a fresh epoch matches no stored tag
  assign visited  = !change && (tag == epoch_q);
  assign fire     = qual && !visited;

  assign initial_d = initial_q[TW-1] ? s1_cur_q : initial_q;
  assign target    = s1_nxt_q[TW-1] ? initial_d : s1_nxt_q;

  ftlpf_visit_map #(
    .Depth (MAX_LINES),
    .IdxW  (IdxW)
  ) u_visit_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (in_addr),
    .rd_tag_o    (rd_tag),
    .wr_en_i     (adv && fire),
    .wr_addr_i   (s1_addr),
    .wr_tag_i    (epoch_d),
    .clr_start_i (clr_start),
    .clr_busy_o  (clr_busy)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_per_tile_q <= ftlpf_pkg::TileLinesRst;
      s1_valid_q       <= 1'b0;
      active_q         <= '1;
      initial_q        <= '1;
      epoch_q          <= '0;
      fw_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        lines_per_tile_q <= cfg_data_i;
      end

      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end

      if (clr_start) begin
        epoch_q    <= '0;
        fw_valid_q <= 1'b0;
      end else if (adv) begin
        fw_valid_q <= fire;
        if (qual) begin
          active_q  <= s1_cur_q;
          initial_q <= initial_d;
          epoch_q   <= epoch_d;
        end
      end

      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q     <= cur_tile_i;
      s1_req_q     <= req_tile_i;
      s1_line_q    <= line_index_i;
      s1_nxt_q     <= next_tile_i;
      s1_payload_q <= request_payload_i;
    end
    if (adv) begin
      fw_addr_q     <= s1_addr;
      fw_tag_q      <= epoch_d;
      out_do_q      <= fire;
      out_tile_q    <= fire ? target[TILE_ID_BITS-1:0] : '0;
      out_payload_q <= fire ? s1_payload_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign do_prefetch_o      = out_do_q;
  assign prefetch_tile_o    = out_tile_q;
  assign prefetch_payload_o = out_payload_q;

endmodule

`default_nettype wire
